// ===== hdl/s2c_pkg.sv =====
// Package for the spherical to Cartesian direction block: item types, constants and helpers.
package s2c_pkg;

    // Default number of rotation stages in each sine/cosine unit.
    localparam int DEF_TRIG_STAGES = 30;

    // Angle constants in Q30: pi and pi/2 truncated, two pi as twice the truncated pi.
    localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;

    // Input and result items.
    typedef struct packed {
        logic signed [31:0] polar_angle;
        logic signed [31:0] azimuth_angle;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] east_component;
        logic signed [31:0] north_component;
        logic signed [31:0] up_component;
        logic               last_result;
    } t_out_item;

    // Angles after range reduction and folding.
    typedef struct packed {
        logic signed [33:0] at;
        logic signed [33:0] ap;
        logic               ft;
        logic               fp;
        logic               last;
    } t_fold;

    // One rotation lane: vector in Q32, residual angle in Q30.
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
    } t_lane;

    typedef struct packed {
        t_lane th;
        t_lane ph;
        logic  ft;
        logic  fp;
        logic  last;
    } t_rot;

    // Sines and cosines in Q30.
    typedef struct packed {
        logic signed [31:0] st;
        logic signed [31:0] ct;
        logic signed [31:0] sp;
        logic signed [31:0] cp;
        logic               last;
    } t_trig;

    // Raw products before rounding.
    typedef struct packed {
        logic signed [63:0] pe;
        logic signed [63:0] pn;
        logic signed [31:0] ct;
        logic               last;
    } t_prod;

    // Arctangent table entry i, floor(atan(2^-i) * 2^30).
    function automatic logic signed [33:0] atan_entry(input int i);
        logic signed [33:0] e;
        case (i)
            0: e = 34'sd843314856;
            1: e = 34'sd497837829;
            2: e = 34'sd263043836;
            3: e = 34'sd133525158;
            4: e = 34'sd67021686;
            5: e = 34'sd33543515;
            6: e = 34'sd16775850;
            7: e = 34'sd8388437;
            8: e = 34'sd4194282;
            9: e = 34'sd2097149;
            default: begin
                if (i <= 30) begin
                    e = (34'sd1 <<< (30 - i)) - 34'sd1;
                end else begin
                    e = 34'sd0;
                end
            end
        endcase
        return e;
    endfunction

    // Gain compensation in Q32: largest K with K^2 * G <= 1, G built in Q62.
    function automatic logic [31:0] gain_k(input int stages);
        logic [63:0]  g;
        logic [63:0]  t;
        logic [63:0]  tt;
        logic [127:0] p;
        logic [31:0]  k;
        g = 64'd1 << 62;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        k = 32'd0;
        for (int b = 31; b >= 0; b--) begin
            t  = {32'd0, k} | (64'd1 << b);
            tt = t * t;
            p  = {64'd0, tt} * {64'd0, g};
            if (p <= (128'd1 << 126)) begin
                k = t[31:0];
            end
        end
        return k;
    endfunction

    // Clamp a value to plus or minus one in Q30.
    function automatic logic signed [31:0] limit_one(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > Q30_ONE) begin
            r = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            r = -Q30_ONE;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    // One micro-rotation step with shift i.
    function automatic t_lane rot_step(input t_lane l, input int i);
        t_lane              r;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (!l.z[33]) begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atan_entry(i);
        end else begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atan_entry(i);
        end
        return r;
    endfunction

    // Reduce a Q28 angle to Q30 in [-pi, pi).
    function automatic logic signed [33:0] reduce(input logic signed [31:0] ang);
        logic signed [34:0] a;
        logic signed [34:0] r;
        a = {{3{ang[31]}}, ang} <<< 2;
        if (a >= Q30_PI) begin
            r = a - Q30_TWO_PI;
        end else if (a < -Q30_PI) begin
            r = a + Q30_TWO_PI;
        end else begin
            r = a;
        end
        return r[33:0];
    endfunction

    // Apply the fold sign, go from Q32 to Q30 with rounding, then clamp.
    function automatic logic signed [31:0] to_q30(input logic signed [35:0] v,
                                                  input logic flip);
        logic signed [35:0] s;
        logic signed [35:0] r;
        s = flip ? -v : v;
        r = (s + 36'sd2) >>> 2;
        return limit_one({{28{r[35]}}, r});
    endfunction

    // Round a Q60 product to Q30 and clamp.
    function automatic logic signed [31:0] round_prod(input logic signed [63:0] p);
        return limit_one((p + 64'sd536870912) >>> 30);
    endfunction

endpackage

// ===== hdl/spherical_to_cartesian_direction.sv =====
// Top level: pipelined conversion of polar and azimuth angles to a unit direction vector.
//
// Input channel: i_in_valid / o_in_ready carry i_in_item (theta and phi, Q4.28,
// and a last flag). Output channel: o_out_valid / i_out_ready carry o_out_item
// (east, north and up components, Q2.30 clamped to plus or minus one, and the
// copied last flag). An item moves on each edge where valid and ready are high.
//
// Every item passes through TRIG_STAGES + 5 register stages: range reduction,
// folding into plus or minus pi/2, TRIG_STAGES rotation stages of the two
// sine/cosine units working side by side, rounding, the products and their
// rounding. One item is taken in every cycle unless every stage is full and the
// receiver stalls; the rotation chain dominates the latency.
//
// Each stage holds a valid bit and advances when it is empty or the stage after
// it moves, so gaps in the pipeline close up while the receiver stalls and new
// items are still taken until every stage is full. Reset empties all stages;
// the block holds no other state.
module spherical_to_cartesian_direction #(
    parameter int TRIG_STAGES = s2c_pkg::DEF_TRIG_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  s2c_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output s2c_pkg::t_out_item  o_out_item
);
    import s2c_pkg::*;

    localparam int          NS     = TRIG_STAGES + 5;
    localparam logic [31:0] GAIN_K = gain_k(TRIG_STAGES);

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;

    t_fold     r_red;
    t_fold     r_fold;
    t_rot      r_rot [TRIG_STAGES];
    t_rot      w_rot_in [TRIG_STAGES];
    t_trig     r_trig;
    t_prod     r_prod;
    t_out_item r_out;

    // Stage enables: a stage loads when it is empty or its successor moves.
    assign w_en[NS] = i_out_ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Range reduction into [-pi, pi).
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_red.at   <= reduce(i_in_item.polar_angle);
            r_red.ap   <= reduce(i_in_item.azimuth_angle);
            r_red.ft   <= 1'b0;
            r_red.fp   <= 1'b0;
            r_red.last <= i_in_item.last_item;
        end
    end

    // Fold into [-pi/2, pi/2], remembering the sign flip.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_fold.last <= r_red.last;
            if (35'(r_red.at) > Q30_HALF_PI) begin
                r_fold.at <= 34'(35'(r_red.at) - Q30_PI);
                r_fold.ft <= 1'b1;
            end else if (35'(r_red.at) < -Q30_HALF_PI) begin
                r_fold.at <= 34'(35'(r_red.at) + Q30_PI);
                r_fold.ft <= 1'b1;
            end else begin
                r_fold.at <= r_red.at;
                r_fold.ft <= 1'b0;
            end
            if (35'(r_red.ap) > Q30_HALF_PI) begin
                r_fold.ap <= 34'(35'(r_red.ap) - Q30_PI);
                r_fold.fp <= 1'b1;
            end else if (35'(r_red.ap) < -Q30_HALF_PI) begin
                r_fold.ap <= 34'(35'(r_red.ap) + Q30_PI);
                r_fold.fp <= 1'b1;
            end else begin
                r_fold.ap <= r_red.ap;
                r_fold.fp <= 1'b0;
            end
        end
    end

    // Rotation stages: the vector starts at (K, 0) with the folded angle.
    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
        if (i == 0) begin : g_first
            always_comb begin
                w_rot_in[i].th.x = {4'd0, GAIN_K};
                w_rot_in[i].th.y = '0;
                w_rot_in[i].th.z = r_fold.at;
                w_rot_in[i].ph.x = {4'd0, GAIN_K};
                w_rot_in[i].ph.y = '0;
                w_rot_in[i].ph.z = r_fold.ap;
                w_rot_in[i].ft   = r_fold.ft;
                w_rot_in[i].fp   = r_fold.fp;
                w_rot_in[i].last = r_fold.last;
            end
        end else begin : g_next
            assign w_rot_in[i] = r_rot[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en[i+2]) begin
                r_rot[i].th   <= rot_step(w_rot_in[i].th, i);
                r_rot[i].ph   <= rot_step(w_rot_in[i].ph, i);
                r_rot[i].ft   <= w_rot_in[i].ft;
                r_rot[i].fp   <= w_rot_in[i].fp;
                r_rot[i].last <= w_rot_in[i].last;
            end
        end
    end

    // Undo the fold and round the sines and cosines to Q30.
    always_ff @(posedge i_clk) begin
        if (w_en[TRIG_STAGES+2]) begin
            r_trig.ct   <= to_q30(r_rot[TRIG_STAGES-1].th.x, r_rot[TRIG_STAGES-1].ft);
            r_trig.st   <= to_q30(r_rot[TRIG_STAGES-1].th.y, r_rot[TRIG_STAGES-1].ft);
            r_trig.cp   <= to_q30(r_rot[TRIG_STAGES-1].ph.x, r_rot[TRIG_STAGES-1].fp);
            r_trig.sp   <= to_q30(r_rot[TRIG_STAGES-1].ph.y, r_rot[TRIG_STAGES-1].fp);
            r_trig.last <= r_rot[TRIG_STAGES-1].last;
        end
    end

    // Horizontal products.
    always_ff @(posedge i_clk) begin
        if (w_en[TRIG_STAGES+3]) begin
            r_prod.pe   <= 64'(r_trig.st) * 64'(r_trig.cp);
            r_prod.pn   <= 64'(r_trig.st) * 64'(r_trig.sp);
            r_prod.ct   <= r_trig.ct;
            r_prod.last <= r_trig.last;
        end
    end

    // Round the products into the output register.
    always_ff @(posedge i_clk) begin
        if (w_en[TRIG_STAGES+4]) begin
            r_out.east_component  <= round_prod(r_prod.pe);
            r_out.north_component <= round_prod(r_prod.pn);
            r_out.up_component    <= r_prod.ct;
            r_out.last_result     <= r_prod.last;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];
    assign o_out_item  = r_out;

    // The input side only stalls when every stage is full and the outlet is held.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld) && !i_out_ready)
        else $error("input stalled while the pipeline has room");

    // Folded angles lie within plus or minus pi/2.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (35'(r_fold.at) <= Q30_HALF_PI) && (35'(r_fold.at) >= -Q30_HALF_PI)
                  && (35'(r_fold.ap) <= Q30_HALF_PI) && (35'(r_fold.ap) >= -Q30_HALF_PI))
        else $error("folded angle out of range");

    // Every delivered component is clamped to plus or minus one.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (64'(o_out_item.east_component) <= Q30_ONE)
         && (64'(o_out_item.east_component) >= -Q30_ONE)
         && (64'(o_out_item.north_component) <= Q30_ONE)
         && (64'(o_out_item.north_component) >= -Q30_ONE)
         && (64'(o_out_item.up_component) <= Q30_ONE)
         && (64'(o_out_item.up_component) >= -Q30_ONE))
        else $error("output component exceeds unit range");

endmodule
